@@ rtl/core/vcg_pkg.sv @@
`timescale 1ns / 1ps

package vcg_pkg;

  // Grid geometry and storage
  localparam int AXIS_MAX    = 64;
  localparam int STORE_DEPTH = 262144;
  localparam int LABEL_BITS  = 8;

  // Fixed field widths of the ports
  localparam int POINT_W     = 32;
  localparam int EDGE_W      = 31;
  localparam int CELLS_CFG_W = 7;
  localparam int INDEX_W     = 18;
  localparam int LABEL_W     = 8;
  localparam int COUNT_W     = 19;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Derived internal widths
  localparam int CELL_W   = $clog2(AXIS_MAX + 1);
  localparam int MAC_W    = 3 * CELL_W + 1;
  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int TALLY_W  = $clog2(STORE_DEPTH + 1);
  localparam int IDX_A_W  = (MAC_W > INDEX_W) ? MAC_W : INDEX_W;
  localparam int IDX_W    = (IDX_A_W > ADDR_W) ? IDX_A_W : ADDR_W;
  localparam int SUB_W    = POINT_W + 2;
  localparam int REM_W    = EDGE_W;
  localparam int STEP_W   = $clog2(CELL_W);

  typedef enum logic [1:0] {
    KIND_RD_PT  = 2'd0,
    KIND_WR_PT  = 2'd1,
    KIND_RD_IDX = 2'd2,
    KIND_WR_IDX = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_CELL_EDGE = 3'd3,
    REG_CELLS_X   = 3'd4,
    REG_CELLS_Y   = 3'd5,
    REG_CELLS_Z   = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OFS,
    ST_PRE,
    ST_DIV,
    ST_AXC,
    ST_LIN1,
    ST_LIN2,
    ST_MUL1,
    ST_MUL2,
    ST_RANGE,
    ST_MRD,
    ST_MRES,
    ST_MISS,
    ST_OUT
  } state_e;

endpackage

@@ rtl/core/voxel_class_grid_core.sv @@
`timescale 1ns / 1ps
// Point items run through a restoring divider, one quotient bit per cycle on one shared
// subtractor; an item that falls outside the grid ends early.
// One item in flight; the next is taken once its result is loaded into the output register.
// Reset restores register defaults, then a clearing pass over all STORE_DEPTH (262144) entries
// zeroes every label while input is stalled; configuration writes are taken throughout.
module voxel_class_grid_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [vcg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [vcg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         kind_i,
  input  logic signed [vcg_pkg::POINT_W-1:0] point_x_i,
  input  logic signed [vcg_pkg::POINT_W-1:0] point_y_i,
  input  logic signed [vcg_pkg::POINT_W-1:0] point_z_i,
  input  logic [vcg_pkg::INDEX_W-1:0]        cell_index_i,
  input  logic [vcg_pkg::LABEL_W-1:0]        label_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [vcg_pkg::INDEX_W-1:0]        cell_index_out_o,
  output logic                               in_grid_o,
  output logic [vcg_pkg::LABEL_W-1:0]        label_out_o,
  output logic                               occupied_o,
  output logic [vcg_pkg::COUNT_W-1:0]        occupied_count_o
);

  localparam int CellW  = vcg_pkg::CELL_W;
  localparam int MacW   = vcg_pkg::MAC_W;
  localparam int AddrW  = vcg_pkg::ADDR_W;
  localparam int IdxW   = vcg_pkg::IDX_W;
  localparam int SubW   = vcg_pkg::SUB_W;
  localparam int RemW   = vcg_pkg::REM_W;
  localparam int StepW  = vcg_pkg::STEP_W;
  localparam int TallyW = vcg_pkg::TALLY_W;
  localparam int LabW   = vcg_pkg::LABEL_BITS;
  localparam int PointW = vcg_pkg::POINT_W;
  localparam int EdgeW  = vcg_pkg::EDGE_W;
  localparam int CellsW = vcg_pkg::CELLS_CFG_W;
  localparam int IndexW = vcg_pkg::INDEX_W;
  localparam int LabOW  = vcg_pkg::LABEL_W;
  localparam int CountW = vcg_pkg::COUNT_W;
  localparam int Depth  = vcg_pkg::STORE_DEPTH;
  localparam int AxMax  = vcg_pkg::AXIS_MAX;

  function automatic logic [CellW-1:0] cells_clamp(input logic [CellsW-1:0] c);
    if (32'(c) > 32'(AxMax)) begin
      return CellW'(AxMax);
    end
    return CellW'(c);
  endfunction

  // configuration registers
  logic signed [PointW-1:0] origin_x_q, origin_y_q, origin_z_q;
  logic [EdgeW-1:0]         cell_edge_q;
  logic [CellsW-1:0]        cells_x_q, cells_y_q, cells_z_q;

  // control
  vcg_pkg::state_e state_q, state_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  logic [TallyW-1:0] cnt_q, cnt_d;

  // datapath
  vcg_pkg::kind_e   kind_q, kind_d;
  vcg_pkg::axis_e   axis_q, axis_d;
  logic [PointW-1:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic [LabW-1:0]   lab_q, lab_d;
  logic [PointW-1:0] off_q, off_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [CellW-1:0]  low_q, low_d;
  logic [CellW-1:0]  quo_q, quo_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [CellW-1:0]  ix_q, ix_d, iy_q, iy_d, iz_q, iz_d;
  logic [MacW-1:0]   mac_q, mac_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              res_in_q, res_in_d;
  logic [IdxW-1:0]   res_idx_q, res_idx_d;
  logic [LabW-1:0]   res_lab_q, res_lab_d;
  logic [IndexW-1:0] out_idx_q, out_idx_d;
  logic              out_in_q, out_in_d;
  logic [LabOW-1:0]  out_lab_q, out_lab_d;
  logic              out_occ_q, out_occ_d;
  logic [CountW-1:0] out_cnt_q, out_cnt_d;

  // shared units
  logic [SubW-1:0]     sub_a, sub_b, sub_diff;
  logic [CellW-1:0]    mac_a, mac_c;
  logic [2*CellW-1:0]  mac_b;
  logic [MacW-1:0]     mac_y;

  // label store
  logic [LabW-1:0]  mem [Depth];
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [LabW-1:0]  mem_wdata, mem_rdata_q;

  logic [CellW-1:0]  cx, cy, cz, cax_sel;
  logic [PointW-1:0] p_sel, org_sel;
  logic [EdgeW-1:0]  edge_eff;
  logic              is_point, is_write;

  assign cx        = cells_clamp(cells_x_q);
  assign cy        = cells_clamp(cells_y_q);
  assign cz        = cells_clamp(cells_z_q);
  assign edge_eff  = (cell_edge_q == '0) ? EdgeW'(1) : cell_edge_q;
  assign is_point  = (kind_q == vcg_pkg::KIND_RD_PT) || (kind_q == vcg_pkg::KIND_WR_PT);
  assign is_write  = (kind_q == vcg_pkg::KIND_WR_PT) || (kind_q == vcg_pkg::KIND_WR_IDX);
  assign sub_diff  = sub_a - sub_b;
  assign mac_y     = MacW'(mac_a) * MacW'(mac_b) + MacW'(mac_c);
  assign mem_raddr = idx_q[AddrW-1:0];

  assign cfg_ready_o      = 1'b1;
  assign in_stall_o       = (state_q != vcg_pkg::ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign cell_index_out_o = out_idx_q;
  assign in_grid_o        = out_in_q;
  assign label_out_o      = out_lab_q;
  assign occupied_o       = out_occ_q;
  assign occupied_count_o = out_cnt_q;

  always_comb begin
    case (axis_q)
      vcg_pkg::AX_X: begin
        p_sel = px_q; org_sel = origin_x_q; cax_sel = cx;
      end
      vcg_pkg::AX_Y: begin
        p_sel = py_q; org_sel = origin_y_q; cax_sel = cy;
      end
      default: begin
        p_sel = pz_q; org_sel = origin_z_q; cax_sel = cz;
      end
    endcase
  end

  always_comb begin
    logic [RemW:0] cand;
    cand        = {rem_q, low_q[CellW-1]};
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    kind_d      = kind_q;
    axis_d      = axis_q;
    px_d        = px_q;
    py_d        = py_q;
    pz_d        = pz_q;
    lab_d       = lab_q;
    off_d       = off_q;
    rem_d       = rem_q;
    low_d       = low_q;
    quo_d       = quo_q;
    step_d      = step_q;
    ix_d        = ix_q;
    iy_d        = iy_q;
    iz_d        = iz_q;
    mac_d       = mac_q;
    idx_d       = idx_q;
    res_in_d    = res_in_q;
    res_idx_d   = res_idx_q;
    res_lab_d   = res_lab_q;
    out_idx_d   = out_idx_q;
    out_in_d    = out_in_q;
    out_lab_d   = out_lab_q;
    out_occ_d   = out_occ_q;
    out_cnt_d   = out_cnt_q;
    sub_a       = '0;
    sub_b       = '0;
    mac_a       = '0;
    mac_b       = '0;
    mac_c       = '0;
    mem_we      = 1'b0;
    mem_waddr   = mem_raddr;
    mem_wdata   = '0;

    // drop the output word once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      vcg_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = vcg_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + AddrW'(1);
        end
      end
      vcg_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          kind_d = vcg_pkg::kind_e'(kind_i);
          px_d   = point_x_i;
          py_d   = point_y_i;
          pz_d   = point_z_i;
          lab_d  = LabW'(label_in_i);
          idx_d  = IdxW'(cell_index_i);
          axis_d = vcg_pkg::AX_X;
          if ((vcg_pkg::kind_e'(kind_i) == vcg_pkg::KIND_RD_PT) ||
              (vcg_pkg::kind_e'(kind_i) == vcg_pkg::KIND_WR_PT)) begin
            state_d = vcg_pkg::ST_OFS;
          end else begin
            state_d = vcg_pkg::ST_MUL1;
          end
        end
      end
      vcg_pkg::ST_OFS: begin
        sub_a = {{2{p_sel[PointW-1]}}, p_sel};
        sub_b = {{2{org_sel[PointW-1]}}, org_sel};
        if (sub_diff[SubW-1]) begin
          state_d = vcg_pkg::ST_MISS;
        end else begin
          off_d   = sub_diff[PointW-1:0];
          state_d = vcg_pkg::ST_PRE;
        end
      end
      vcg_pkg::ST_PRE: begin
        // quotient fits in CellW bits only if the high part stays below the edge
        sub_a = SubW'(off_q >> CellW);
        sub_b = SubW'(edge_eff);
        if (!sub_diff[SubW-1]) begin
          state_d = vcg_pkg::ST_MISS;
        end else begin
          rem_d   = RemW'(off_q >> CellW);
          low_d   = off_q[CellW-1:0];
          quo_d   = '0;
          step_d  = StepW'(CellW - 1);
          state_d = vcg_pkg::ST_DIV;
        end
      end
      vcg_pkg::ST_DIV: begin
        sub_a = SubW'(cand);
        sub_b = SubW'(edge_eff);
        if (!sub_diff[SubW-1]) begin
          rem_d = sub_diff[RemW-1:0];
          quo_d = {quo_q[CellW-2:0], 1'b1};
        end else begin
          rem_d = cand[RemW-1:0];
          quo_d = {quo_q[CellW-2:0], 1'b0};
        end
        low_d = low_q << 1;
        if (step_q == '0) begin
          state_d = vcg_pkg::ST_AXC;
        end else begin
          step_d = step_q - StepW'(1);
        end
      end
      vcg_pkg::ST_AXC: begin
        if (quo_q >= cax_sel) begin
          state_d = vcg_pkg::ST_MISS;
        end else begin
          case (axis_q)
            vcg_pkg::AX_X: begin
              ix_d    = quo_q;
              axis_d  = vcg_pkg::AX_Y;
              state_d = vcg_pkg::ST_OFS;
            end
            vcg_pkg::AX_Y: begin
              iy_d    = quo_q;
              axis_d  = vcg_pkg::AX_Z;
              state_d = vcg_pkg::ST_OFS;
            end
            vcg_pkg::AX_Z: begin
              iz_d    = quo_q;
              state_d = vcg_pkg::ST_LIN1;
            end
            default: begin
              state_d = vcg_pkg::ST_MISS;
            end
          endcase
        end
      end
      vcg_pkg::ST_LIN1: begin
        mac_a   = cy;
        mac_b   = (2*CellW)'(iz_q);
        mac_c   = iy_q;
        mac_d   = mac_y;
        state_d = vcg_pkg::ST_LIN2;
      end
      vcg_pkg::ST_LIN2: begin
        mac_a   = cx;
        mac_b   = mac_q[2*CellW-1:0];
        mac_c   = ix_q;
        idx_d   = IdxW'(mac_y);
        state_d = vcg_pkg::ST_RANGE;
      end
      vcg_pkg::ST_MUL1: begin
        mac_a   = cx;
        mac_b   = (2*CellW)'(cy);
        mac_d   = mac_y;
        state_d = vcg_pkg::ST_MUL2;
      end
      vcg_pkg::ST_MUL2: begin
        // grid volume for the index range check
        mac_a   = cz;
        mac_b   = mac_q[2*CellW-1:0];
        mac_d   = mac_y;
        state_d = vcg_pkg::ST_RANGE;
      end
      vcg_pkg::ST_RANGE: begin
        if ((64'(idx_q) < 64'(Depth)) && (is_point || (idx_q < IdxW'(mac_q)))) begin
          state_d = vcg_pkg::ST_MRD;
        end else begin
          state_d = vcg_pkg::ST_MISS;
        end
      end
      vcg_pkg::ST_MRD: begin
        state_d = vcg_pkg::ST_MRES;
      end
      vcg_pkg::ST_MRES: begin
        res_in_d  = 1'b1;
        res_idx_d = idx_q;
        if (is_write) begin
          mem_we    = 1'b1;
          mem_wdata = lab_q;
          res_lab_d = lab_q;
          if ((mem_rdata_q != '0) && (lab_q == '0)) begin
            cnt_d = cnt_q - TallyW'(1);
          end else if ((mem_rdata_q == '0) && (lab_q != '0)) begin
            cnt_d = cnt_q + TallyW'(1);
          end
        end else begin
          res_lab_d = mem_rdata_q;
        end
        state_d = vcg_pkg::ST_OUT;
      end
      vcg_pkg::ST_MISS: begin
        res_in_d  = 1'b0;
        res_idx_d = '0;
        res_lab_d = '0;
        state_d   = vcg_pkg::ST_OUT;
      end
      vcg_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_idx_d   = IndexW'(res_idx_q);
          out_in_d    = res_in_q;
          out_lab_d   = LabOW'(res_lab_q);
          out_occ_d   = res_in_q && (res_lab_q != '0);
          out_cnt_d   = CountW'(cnt_q);
          state_d     = vcg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vcg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vcg_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      origin_z_q  <= '0;
      cell_edge_q <= EdgeW'(65536);
      cells_x_q   <= CellsW'(64);
      cells_y_q   <= CellsW'(64);
      cells_z_q   <= CellsW'(64);
    end else if (cfg_valid_i) begin
      case (vcg_pkg::cfg_reg_e'(cfg_index_i))
        vcg_pkg::REG_ORIGIN_X:  origin_x_q  <= cfg_data_i;
        vcg_pkg::REG_ORIGIN_Y:  origin_y_q  <= cfg_data_i;
        vcg_pkg::REG_ORIGIN_Z:  origin_z_q  <= cfg_data_i;
        vcg_pkg::REG_CELL_EDGE: cell_edge_q <= cfg_data_i[EdgeW-1:0];
        vcg_pkg::REG_CELLS_X:   cells_x_q   <= cfg_data_i[CellsW-1:0];
        vcg_pkg::REG_CELLS_Y:   cells_y_q   <= cfg_data_i[CellsW-1:0];
        vcg_pkg::REG_CELLS_Z:   cells_z_q   <= cfg_data_i[CellsW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    axis_q    <= axis_d;
    px_q      <= px_d;
    py_q      <= py_d;
    pz_q      <= pz_d;
    lab_q     <= lab_d;
    off_q     <= off_d;
    rem_q     <= rem_d;
    low_q     <= low_d;
    quo_q     <= quo_d;
    step_q    <= step_d;
    ix_q      <= ix_d;
    iy_q      <= iy_d;
    iz_q      <= iz_d;
    mac_q     <= mac_d;
    idx_q     <= idx_d;
    res_in_q  <= res_in_d;
    res_idx_q <= res_idx_d;
    res_lab_q <= res_lab_d;
    out_idx_q <= out_idx_d;
    out_in_q  <= out_in_d;
    out_lab_q <= out_lab_d;
    out_occ_q <= out_occ_d;
    out_cnt_q <= out_cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= TallyW'(Depth))
    else $error("occupied count above store depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + TallyW'(1)) ||
             (cnt_q == $past(cnt_q) - TallyW'(1)))
    else $error("occupied count moved by more than one");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !in_grid_o) |->
      ((cell_index_out_o == '0) && (label_out_o == '0) && !occupied_o))
    else $error("outside-grid word carries nonzero fields");

  a_mem_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == vcg_pkg::ST_CLEAR) ||
                ((state_q == vcg_pkg::ST_MRES) && is_write && (64'(idx_q) < 64'(Depth)))))
    else $error("label store written outside clear or in-grid write");

endmodule
